// File: hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants for the piece randomizer
// Holds the controller states, the command and status bundles, the field
// widths, and the small tables used when a piece is rerolled.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int unsigned SR_W    = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned PIECE_W = 3;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned SEED_W  = 24;

  // Previous-piece code meaning no piece has been produced yet.
  localparam logic [PIECE_W-1:0] NO_PIECE = 3'd7;
  // Step count that the state holds after reset.
  localparam logic [STEP_W-1:0] STEPS_RESET = 5'd19;
  localparam logic [STEP_W-1:0] STEP_BIAS   = 5'd3;
  localparam logic [STEP_W-1:0] STEP_ZERO_AS = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PICK,
    ST_REROLL
  } lpr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // input transfer: optional reload, bump counter
    logic shift;         // advance the shift register by one step
    logic finish_direct; // take the first candidate as the piece
    logic finish_reroll; // take the rerolled value as the piece
  } lpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_step;     // the current shift is the last of this piece
    logic need_reroll;   // first candidate is the none code or a repeat
  } lpr_status_t;

  // Offset added on a reroll, indexed by the previous piece.
  function automatic logic [4:0] reroll_offset(input logic [PIECE_W-1:0] prev);
    logic [4:0] off;
    unique case (prev)
      3'd0:    off = 5'd2;
      3'd1:    off = 5'd7;
      3'd2:    off = 5'd8;
      3'd3:    off = 5'd10;
      3'd4:    off = 5'd11;
      3'd5:    off = 5'd14;
      3'd6:    off = 5'd18;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  // Remainder by seven of a value that never exceeds 25.
  function automatic logic [PIECE_W-1:0] mod7(input logic [4:0] v);
    logic [4:0] r;
    if (v >= 5'd21) begin
      r = v - 5'd21;
    end else if (v >= 5'd14) begin
      r = v - 5'd14;
    end else if (v >= 5'd7) begin
      r = v - 5'd7;
    end else begin
      r = v;
    end
    return r[PIECE_W-1:0];
  endfunction

endpackage

// File: hdl/lfsr_piece_randomizer_core.sv
// ----------------------------------------------------------------------------
// lfsr_piece_randomizer_core: seven-kind piece randomizer
// A 16-bit shift register advanced a seed-dependent number of steps per
// piece picks one of seven kinds, rerolling once on a repeat or the none code.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                    Direction
//   -------  ---------------------------------------  ---------
//   input    in_valid, in_stall, in_restart,          in
//            in_restart_seed
//   result   out_valid, out_stall, out_piece          out
//
// A piece passes through an accept, 4 to 19 shift steps with the shift
// register advancing one step per cycle, a pick, and a reroll when one is
// needed.
// One item is in flight at a time; a new item is taken while the previous
// piece still waits in the output register.
// Reset is synchronous: the shift register and counter clear, the previous
// piece becomes none and the step count becomes nineteen.
// A stalled output holds the piece and the block waits before finishing the
// next one.
module lfsr_piece_randomizer_core
  import lpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  input  logic [SEED_W-1:0]  in_restart_seed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PIECE_W-1:0] out_piece
);

  lpr_cmd_t    cmd;
  lpr_status_t status;

  // Sequencing controller.
  lpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Randomizer datapath.
  lpr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_restart      (in_restart),
    .in_restart_seed (in_restart_seed),
    .cmd             (cmd),
    .status          (status),
    .out_piece       (out_piece)
  );

endmodule

// File: hdl/lpr_ctrl.sv
// ----------------------------------------------------------------------------
// lpr_ctrl: sequencing controller for the piece randomizer
// Walks each piece through its shift steps, the pick and the optional reroll,
// and owns the handshake flags of both channels.
// ----------------------------------------------------------------------------
module lpr_ctrl
  import lpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  lpr_status_t status,
  output lpr_cmd_t    cmd
);

  lpr_state_t state_r;
  lpr_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  // The output register can take a new piece when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (status.last_step) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (status.need_reroll) begin
          cmd.shift = 1'b1;
          state_nxt = ST_REROLL;
        end else if (out_free) begin
          cmd.finish_direct = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_REROLL: begin
        if (out_free) begin
          cmd.finish_reroll = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A finished piece fills the output register; a transfer empties it.
  always_comb begin
    if (cmd.finish_direct || cmd.finish_reroll) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

// File: hdl/lpr_dp.sv
// ----------------------------------------------------------------------------
// lpr_dp: datapath of the piece randomizer
// Holds the shift register, piece counter, previous piece, step count and
// the output register, and carries out the controller's commands.
// ----------------------------------------------------------------------------
module lpr_dp
  import lpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_restart,
  input  logic [SEED_W-1:0]  in_restart_seed,
  input  lpr_cmd_t           cmd,
  output lpr_status_t        status,
  output logic [PIECE_W-1:0] out_piece
);

  logic [SR_W-1:0]    shift_reg_r;
  logic [SR_W-1:0]    shift_reg_nxt;
  logic [CNT_W-1:0]   spawn_r;
  logic [CNT_W-1:0]   spawn_nxt;
  logic [PIECE_W-1:0] last_r;
  logic [PIECE_W-1:0] last_nxt;
  logic [STEP_W-1:0]  steps_r;
  logic [STEP_W-1:0]  steps_nxt;
  logic [STEP_W-1:0]  cnt_r;
  logic [STEP_W-1:0]  cnt_nxt;
  logic [PIECE_W-1:0] piece_r;
  logic [PIECE_W-1:0] piece_nxt;

  logic [SR_W-1:0]    shifted;
  logic [STEP_W-1:0]  seed_steps;
  logic [3:0]         seed_hi;
  logic [PIECE_W-1:0] cand;
  logic [PIECE_W-1:0] rerolled;

  // One Fibonacci step: feedback is bit 1 xor bit 9, entering at the top.
  assign shifted = {shift_reg_r[1] ^ shift_reg_r[9], shift_reg_r[SR_W-1:1]};

  // Step count derived from a seed's counter byte; a zero high nibble
  // counts as sixteen.
  assign seed_hi    = in_restart_seed[7:4];
  assign seed_steps = ((seed_hi == 4'd0) ? STEP_ZERO_AS : {1'b0, seed_hi}) + STEP_BIAS;

  // First candidate and the rerolled value.
  assign cand     = shift_reg_r[10:8] + spawn_r[PIECE_W-1:0];
  assign rerolled = mod7({2'b00, shift_reg_r[10:8]} + reroll_offset(last_r));

  assign status.last_step   = (cnt_r == STEP_W'(1));
  assign status.need_reroll = (cand == NO_PIECE) || (cand == last_r);
  assign out_piece          = piece_r;

  // Next values of the state.
  always_comb begin
    shift_reg_nxt = shift_reg_r;
    spawn_nxt     = spawn_r;
    last_nxt      = last_r;
    steps_nxt     = steps_r;
    cnt_nxt       = cnt_r;
    piece_nxt     = piece_r;
    if (cmd.load) begin
      if (in_restart) begin
        shift_reg_nxt = in_restart_seed[SEED_W-1:CNT_W];
        spawn_nxt     = in_restart_seed[CNT_W-1:0] + CNT_W'(1);
        last_nxt      = NO_PIECE;
        steps_nxt     = seed_steps;
        cnt_nxt       = seed_steps;
      end else begin
        spawn_nxt = spawn_r + CNT_W'(1);
        cnt_nxt   = steps_r;
      end
    end
    if (cmd.shift) begin
      shift_reg_nxt = shifted;
      cnt_nxt       = cnt_r - STEP_W'(1);
    end
    if (cmd.finish_direct) begin
      piece_nxt = cand;
      last_nxt  = cand;
    end
    if (cmd.finish_reroll) begin
      piece_nxt = rerolled;
      last_nxt  = rerolled;
    end
  end

  // Randomizer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_reg_r <= '0;
      spawn_r     <= '0;
      last_r      <= NO_PIECE;
      steps_r     <= STEPS_RESET;
    end else begin
      shift_reg_r <= shift_reg_nxt;
      spawn_r     <= spawn_nxt;
      last_r      <= last_nxt;
      steps_r     <= steps_nxt;
    end
  end

  // Step counter and output register carry payload only.
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    piece_r <= piece_nxt;
  end

endmodule

// File: hdl/lpr_checker.sv
// ----------------------------------------------------------------------------
// lpr_checker: port-level checks for the piece randomizer
// Watches the top-level ports and flags piece codes, busy periods and
// handshake behavior that the design must never show.
// ----------------------------------------------------------------------------
module lpr_checker
  import lpr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_restart,
  input logic [SEED_W-1:0]  in_restart_seed,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PIECE_W-1:0] out_piece
);

  logic in_xfer;

  assign in_xfer = in_valid && !in_stall;

  // A stalled request stays and holds its fields until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_restart) && $stable(in_restart_seed))
    else $error("stalled request changed or dropped");

  // A stalled result stays and holds its piece.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_piece))
    else $error("stalled result changed or dropped");

  // A delivered piece is never the none code.
  a_piece_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_piece != NO_PIECE)
    else $error("piece code out of range");

  // Every piece takes at least four shift steps, so the block stays busy.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall ##1 in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken again too soon");

  // A new result appears only at the end of work on an item.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

endmodule

bind lfsr_piece_randomizer_core lpr_checker u_lpr_checker (.*);
